// File: hw/rtl/first_fit_heap_allocator_top_defines.svh
// assertion macros for the heap allocator
// used by first_fit_heap_allocator_top, needs clk and arst_n in scope
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_DEFINES_SVH

`define FFHA_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

`define FFHA_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: hw/rtl/ffha_pkg.sv
// types and constants of the heap allocator
// no dependencies
`default_nettype none
package ffha_pkg;
	localparam int unsigned OFF_W = 25;
	localparam int unsigned ADDR_W = 32;
	localparam logic [31:0] HEAP_BASE_RST = 32'h0100_0000;
	localparam logic [24:0] HEAP_BYTES_RST = 25'(1024 * 1024);

	localparam logic [1:0] CMD_NONE = 2'd0;
	localparam logic [1:0] CMD_INS = 2'd1;
	localparam logic [1:0] CMD_REM = 2'd2;

	localparam logic [1:0] MODE_ALLOC = 2'd0;
	localparam logic [1:0] MODE_REL = 2'd1;
	localparam logic [1:0] MODE_RSZ = 2'd2;

	localparam logic CFG_BASE = 1'b0;
	localparam logic CFG_BYTES = 1'b1;

	typedef struct packed {
		logic [OFF_W-1:0] off;
		logic [OFF_W-1:0] size;
		logic free;
	} seg_t;

	typedef struct packed {
		logic [1:0] op;
		seg_t d;
		logic wen;
		seg_t wd;
	} cell_cmd_t;

	typedef struct packed {
		logic [OFF_W-1:0] need;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] base;
	} search_t;
endpackage
`default_nettype wire

// File: hw/rtl/first_fit_heap_allocator_top.sv
// channel   dir  handshake             payload
// in        in   in_valid/in_ready     mode, block_address, request_size
// out       out  out_valid/out_ready   result_address, success, moved, copy_bytes
// cfg       in   cfg_valid/cfg_ready   cfg_index, cfg_data
// first-fit and address scans step one cell per cycle; a release merges each following free cell
// in S_RELN and S_RELC, a preceding free one in S_RELP, each time shifting the later cells down
// reset clears count, bump pointer and control registers and loads the default heap base and size;
// cell contents stay undefined; a finished result waits in the output register; a new request is taken meanwhile
// depends on ffha_pkg, ffha_cell and first_fit_heap_allocator_top_defines.svh
`default_nettype none
`include "first_fit_heap_allocator_top_defines.svh"
module first_fit_heap_allocator_top import ffha_pkg::*; #(
	parameter int MAX_BLOCKS = 64,
	parameter int HEADER_BYTES = 12
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] mode,
	input wire logic [31:0] block_address,
	input wire logic [23:0] request_size,
	output logic out_valid,
	input wire logic out_ready,
	output logic [31:0] result_address,
	output logic success,
	output logic moved,
	output logic [23:0] copy_bytes,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [31:0] cfg_data
);
	localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [CW-1:0] NMAX = CW'(MAX_BLOCKS);
	localparam logic [OFF_W-1:0] HB = OFF_W'(HEADER_BYTES);
	localparam logic [31:0] HB32 = 32'(HEADER_BYTES);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_FIT = 4'd1;
	localparam logic [3:0] S_AUP = 4'd2;
	localparam logic [3:0] S_MAT = 4'd3;
	localparam logic [3:0] S_MRD = 4'd4;
	localparam logic [3:0] S_RELN = 4'd5;
	localparam logic [3:0] S_RELC = 4'd6;
	localparam logic [3:0] S_RELP = 4'd7;
	localparam logic [3:0] S_RSZC = 4'd8;
	localparam logic [3:0] S_DONE = 4'd9;

	logic [3:0] state_q;
	logic [CW-1:0] cnt_q, idx_q;
	logic [IW-1:0] i_q;
	logic [OFF_W-1:0] bump_q, hbytes_q, need_q, old_q;
	logic [31:0] base_q, addr_q, naddr_q, res_q;
	logic [1:0] op_q;
	logic ph_q, ok_q, mv_q, ov_q;
	seg_t cur_q, rd_q;

	seg_t cells [MAX_BLOCKS];
	logic [MAX_BLOCKS-1:0] fit_v, match_v;
	cell_cmd_t cmd;
	logic [IW-1:0] k, widx, rd_idx, ip1;
	search_t srch;

	logic [1:0] eff_mode;
	logic [OFF_W-1:0] rnd;
	logic ip1_ok, split_ok, grow_ok, app_ok;
	logic [OFF_W:0] grow_sum;
	logic [31:0] aup_addr, app_addr;

	assign in_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = ov_q;

	assign srch = '{need: need_q, addr: addr_q, base: base_q};
	assign ip1 = i_q + IW'(1);
	assign ip1_ok = (CW'(i_q) + CW'(1)) < cnt_q;
	assign split_ok = ({1'b0, rd_q.size} >= ({1'b0, need_q} + {1'b0, HB} + (OFF_W+1)'(8)))
		&& (cnt_q < NMAX);
	assign grow_sum = {1'b0, cur_q.size} + {1'b0, HB} + {1'b0, rd_q.size};
	assign grow_ok = ip1_ok && rd_q.free && (grow_sum >= {1'b0, need_q});
	assign app_ok = (cnt_q < NMAX) &&
		(({2'b0, bump_q} + {2'b0, HB} + {2'b0, need_q}) <= {2'b0, hbytes_q});
	assign aup_addr = base_q + {7'b0, rd_q.off} + HB32;
	assign app_addr = base_q + {7'b0, bump_q} + HB32;
	assign rnd = ({1'b0, request_size} + OFF_W'(7)) & ~OFF_W'(7);

	always_comb begin
		eff_mode = mode;
		if (eff_mode == MODE_RSZ && block_address == 32'd0) eff_mode = MODE_ALLOC;
		if (eff_mode == MODE_RSZ && request_size == 24'd0) eff_mode = MODE_REL;
	end

	genvar j;
	generate
		for (j = 0; j < MAX_BLOCKS; j++) begin : g_cell
			seg_t lft, rgt;
			if (j == 0) begin : g_l0
				assign lft = '0;
			end else begin : g_l
				assign lft = cells[j-1];
			end
			if (j == MAX_BLOCKS - 1) begin : g_rn
				assign rgt = '0;
			end else begin : g_r
				assign rgt = cells[j+1];
			end
			ffha_cell #(.IDX(j), .IW(IW), .HEADER_BYTES(HEADER_BYTES)) u_cell (
				.clk(clk), .cmd(cmd), .k(k), .widx(widx), .srch(srch),
				.left(lft), .right(rgt), .q(cells[j]), .fit(fit_v[j]), .match(match_v[j])
			);
		end
	endgenerate

	always_comb begin
		cmd = '0;
		k = '0;
		widx = '0;
		rd_idx = idx_q[IW-1:0];
		case (state_q)
			S_FIT: begin
				if (idx_q == cnt_q && app_ok) begin
					cmd.wen = 1'b1;
					widx = cnt_q[IW-1:0];
					cmd.wd = '{off: bump_q, size: need_q, free: 1'b0};
				end
			end
			S_AUP: begin
				cmd.wen = 1'b1;
				widx = i_q;
				if (split_ok) begin
					cmd.op = CMD_INS;
					k = ip1;
					cmd.d = '{off: rd_q.off + HB + need_q, size: rd_q.size - need_q - HB,
						free: 1'b1};
					cmd.wd = '{off: rd_q.off, size: need_q, free: 1'b0};
				end else begin
					cmd.wd = '{off: rd_q.off, size: rd_q.size, free: 1'b0};
				end
			end
			S_MRD, S_RELN: rd_idx = ip1;
			S_RELC: begin
				rd_idx = i_q - IW'(1);
				if (ip1_ok && rd_q.free) begin
					cmd.op = CMD_REM;
					k = ip1;
				end else begin
					cmd.wen = 1'b1;
					widx = i_q;
					cmd.wd = cur_q;
				end
			end
			S_RELP: begin
				if (rd_q.free) begin
					cmd.wen = 1'b1;
					widx = i_q - IW'(1);
					cmd.wd = '{off: rd_q.off, size: rd_q.size + HB + cur_q.size, free: 1'b1};
					cmd.op = CMD_REM;
					k = i_q;
				end
			end
			S_RSZC: begin
				if (grow_ok) begin
					cmd.wen = 1'b1;
					widx = i_q;
					cmd.wd = '{off: cur_q.off, size: grow_sum[OFF_W-1:0], free: cur_q.free};
					cmd.op = CMD_REM;
					k = ip1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		rd_q <= cells[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			idx_q <= '0;
			i_q <= '0;
			bump_q <= '0;
			hbytes_q <= HEAP_BYTES_RST;
			base_q <= HEAP_BASE_RST;
			need_q <= '0;
			old_q <= '0;
			addr_q <= '0;
			naddr_q <= '0;
			res_q <= '0;
			op_q <= MODE_ALLOC;
			ph_q <= 1'b0;
			ok_q <= 1'b0;
			mv_q <= 1'b0;
			ov_q <= 1'b0;
			cur_q <= '0;
			result_address <= '0;
			success <= 1'b0;
			moved <= 1'b0;
			copy_bytes <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == {1'b0, CFG_BASE}) base_q <= cfg_data;
				else if (cfg_index == {1'b0, CFG_BYTES}) hbytes_q <= cfg_data[OFF_W-1:0];
			end
			if (state_q == S_DONE && (!ov_q || out_ready)) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						need_q <= rnd;
						addr_q <= block_address;
						idx_q <= '0;
						ph_q <= 1'b0;
						op_q <= eff_mode;
						res_q <= '0;
						mv_q <= 1'b0;
						ok_q <= (eff_mode == MODE_REL) && (block_address == 32'd0);
						case (eff_mode)
							MODE_ALLOC: state_q <= (request_size != 24'd0) ? S_FIT : S_DONE;
							MODE_REL: state_q <= (block_address == 32'd0) ? S_DONE : S_MAT;
							MODE_RSZ: state_q <= S_MAT;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_FIT: begin
					if (idx_q == cnt_q) begin
						if (app_ok) begin
							cnt_q <= cnt_q + CW'(1);
							bump_q <= bump_q + HB + need_q;
							if (ph_q) begin
								naddr_q <= app_addr;
								idx_q <= '0;
								state_q <= S_MAT;
							end else begin
								res_q <= app_addr;
								ok_q <= 1'b1;
								state_q <= S_DONE;
							end
						end else begin
							res_q <= '0;
							ok_q <= 1'b0;
							state_q <= S_DONE;
						end
					end else if (fit_v[idx_q[IW-1:0]]) begin
						i_q <= idx_q[IW-1:0];
						state_q <= S_AUP;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				S_AUP: begin
					if (split_ok) cnt_q <= cnt_q + CW'(1);
					if (ph_q) begin
						naddr_q <= aup_addr;
						idx_q <= '0;
						state_q <= S_MAT;
					end else begin
						res_q <= aup_addr;
						ok_q <= 1'b1;
						state_q <= S_DONE;
					end
				end
				S_MAT: begin
					if (idx_q == cnt_q) begin
						res_q <= '0;
						ok_q <= 1'b0;
						state_q <= S_DONE;
					end else if (match_v[idx_q[IW-1:0]]) begin
						i_q <= idx_q[IW-1:0];
						state_q <= S_MRD;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				S_MRD: begin
					if (op_q == MODE_REL || ph_q) begin
						cur_q <= '{off: rd_q.off, size: rd_q.size, free: 1'b1};
						state_q <= S_RELN;
					end else begin
						cur_q <= rd_q;
						if (rd_q.size >= need_q) begin
							res_q <= addr_q;
							ok_q <= 1'b1;
							state_q <= S_DONE;
						end else begin
							state_q <= S_RSZC;
						end
					end
				end
				S_RSZC: begin
					if (grow_ok) begin
						cnt_q <= cnt_q - CW'(1);
						res_q <= addr_q;
						ok_q <= 1'b1;
						state_q <= S_DONE;
					end else begin
						old_q <= cur_q.size;
						ph_q <= 1'b1;
						idx_q <= '0;
						state_q <= S_FIT;
					end
				end
				S_RELN: state_q <= S_RELC;
				S_RELC: begin
					if (ip1_ok && rd_q.free) begin
						cur_q.size <= cur_q.size + HB + rd_q.size;
						cnt_q <= cnt_q - CW'(1);
						state_q <= S_RELN;
					end else if (i_q != '0) begin
						state_q <= S_RELP;
					end else begin
						ok_q <= 1'b1;
						res_q <= ph_q ? naddr_q : 32'd0;
						mv_q <= ph_q;
						state_q <= S_DONE;
					end
				end
				S_RELP: begin
					if (rd_q.free) cnt_q <= cnt_q - CW'(1);
					ok_q <= 1'b1;
					res_q <= ph_q ? naddr_q : 32'd0;
					mv_q <= ph_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!ov_q || out_ready) begin
						result_address <= res_q;
						success <= ok_q;
						moved <= mv_q;
						copy_bytes <= mv_q ? old_q[23:0] : 24'd0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`FFHA_ASSERT(a_cnt_bound, cnt_q <= NMAX, "segment count above table size")
	`FFHA_ASSERT_NEXT(a_start, in_valid && in_ready, state_q != S_IDLE, "request not started")
	`FFHA_ASSERT(a_aup_idx, (state_q != S_AUP) || (CW'(i_q) < cnt_q), "alloc index out of range")
	`FFHA_ASSERT(a_moved_ok, !out_valid || !moved || success, "move reported without success")
endmodule
`default_nettype wire

// File: hw/rtl/ffha_cell.sv
// one segment cell of the allocator chain: direct writes, insert and remove shifts, fit and match flags
// depends on ffha_pkg
`default_nettype none
module ffha_cell import ffha_pkg::*; #(
	parameter int IDX = 0,
	parameter int IW = 6,
	parameter int HEADER_BYTES = 12
) (
	input wire logic clk,
	input wire cell_cmd_t cmd,
	input wire logic [IW-1:0] k,
	input wire logic [IW-1:0] widx,
	input wire search_t srch,
	input wire seg_t left,
	input wire seg_t right,
	output seg_t q,
	output logic fit,
	output logic match
);
	localparam logic [IW-1:0] ME = IW'(IDX);

	always_ff @(posedge clk) begin
		if (cmd.wen && widx == ME) begin
			q <= cmd.wd;
		end else begin
			case (cmd.op)
				CMD_INS: begin
					if (ME > k) q <= left;
					else if (ME == k) q <= cmd.d;
				end
				CMD_REM: begin
					if (ME >= k) q <= right;
				end
				default: begin
				end
			endcase
		end
	end

	assign fit = q.free && (q.size >= srch.need);
	assign match = (srch.base + {7'b0, q.off} + 32'(HEADER_BYTES)) == srch.addr;
endmodule
`default_nettype wire

// File: test/tb_top.sv
// self-checking testbench for first_fit_heap_allocator_top: a queue-fed driver, a monitor
// and an in-bench heap table predictor that scores every result in order
// depends on ffha_pkg and the allocator rtl
`timescale 1ns / 1ps
module tb_top import ffha_pkg::*; ();

	localparam int BLOCKS = 64;
	localparam int HDR = 12;

	typedef struct {
		logic [1:0] md;
		int pick;
		logic [31:0] adr;
		logic [23:0] sz;
	} heap_req_t;

	typedef struct packed {
		logic [31:0] adr;
		logic ok;
		logic mv;
		logic [23:0] cp;
	} heap_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] mode = MODE_ALLOC;
	logic [31:0] block_address = '0;
	logic [23:0] request_size = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [31:0] result_address;
	logic success;
	logic moved;
	logic [23:0] copy_bytes;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	heap_req_t pending_reqs[$];
	heap_reply_t replies_due[$];
	int errors = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_left = 0;
	bit in_taken = 1'b0;

	// predictor state
	int unsigned seg_off[BLOCKS];
	int unsigned seg_size[BLOCKS];
	bit seg_free[BLOCKS];
	int unsigned seg_cnt = 0;
	int unsigned bump = 0;
	int unsigned base_reg = HEAP_BASE_RST;
	int unsigned bytes_reg = HEAP_BYTES_RST;

	first_fit_heap_allocator_top #(.MAX_BLOCKS(BLOCKS), .HEADER_BYTES(HDR)) dut (.*);

	always #4 clk = ~clk;

	function automatic int unsigned seg_addr(int unsigned i);
		return base_reg + seg_off[i] + HDR;
	endfunction

	function automatic void drop_seg(int unsigned i);
		for (int unsigned j = i; j + 1 < seg_cnt; j++) begin
			seg_off[j] = seg_off[j+1];
			seg_size[j] = seg_size[j+1];
			seg_free[j] = seg_free[j+1];
		end
		seg_cnt--;
	endfunction

	function automatic int find_seg(int unsigned a);
		for (int unsigned i = 0; i < seg_cnt; i++)
			if (seg_addr(i) == a)
				return int'(i);
		return -1;
	endfunction

	function automatic bit first_fit(int unsigned need, output int unsigned a);
		a = 0;
		for (int unsigned i = 0; i < seg_cnt; i++) begin
			if (seg_free[i] && seg_size[i] >= need) begin
				seg_free[i] = 1'b0;
				if (seg_size[i] >= need + HDR + 8 && seg_cnt < BLOCKS) begin
					for (int unsigned j = seg_cnt; j > i + 1; j--) begin
						seg_off[j] = seg_off[j-1];
						seg_size[j] = seg_size[j-1];
						seg_free[j] = seg_free[j-1];
					end
					seg_off[i+1] = seg_off[i] + HDR + need;
					seg_size[i+1] = seg_size[i] - need - HDR;
					seg_free[i+1] = 1'b1;
					seg_size[i] = need;
					seg_cnt++;
				end
				a = seg_addr(i);
				return 1'b1;
			end
		end
		if (seg_cnt >= BLOCKS || bump + HDR + need > bytes_reg)
			return 1'b0;
		seg_off[seg_cnt] = bump;
		seg_size[seg_cnt] = need;
		seg_free[seg_cnt] = 1'b0;
		a = seg_addr(seg_cnt);
		seg_cnt++;
		bump += HDR + need;
		return 1'b1;
	endfunction

	function automatic void free_and_merge(int unsigned i);
		seg_free[i] = 1'b1;
		while (i + 1 < seg_cnt && seg_free[i+1]) begin
			seg_size[i] += HDR + seg_size[i+1];
			drop_seg(i + 1);
		end
		if (i > 0 && seg_free[i-1]) begin
			seg_size[i-1] += HDR + seg_size[i];
			drop_seg(i);
		end
	endfunction

	function automatic heap_reply_t predict_heap_reply(logic [1:0] md, int unsigned a,
			int unsigned sz);
		heap_reply_t r;
		int idx;
		int unsigned need, na, old_size;
		r = '0;
		need = (sz + 7) & ~32'd7;
		if (md == MODE_RSZ && a == 0)
			md = MODE_ALLOC;
		if (md == MODE_RSZ && sz == 0)
			md = MODE_REL;
		if (md == MODE_ALLOC) begin
			if (sz != 0)
				r.ok = first_fit(need, na);
			r.adr = r.ok ? na : 32'd0;
		end else if (md == MODE_REL) begin
			if (a == 0)
				r.ok = 1'b1;
			else begin
				idx = find_seg(a);
				if (idx >= 0) begin
					free_and_merge(idx);
					r.ok = 1'b1;
				end
			end
		end else if (md == MODE_RSZ) begin
			idx = find_seg(a);
			if (idx >= 0) begin
				if (seg_size[idx] >= need) begin
					r.adr = a;
					r.ok = 1'b1;
				end else if (idx + 1 < seg_cnt && seg_free[idx+1] &&
						seg_size[idx] + HDR + seg_size[idx+1] >= need) begin
					seg_size[idx] += HDR + seg_size[idx+1];
					drop_seg(idx + 1);
					r.adr = a;
					r.ok = 1'b1;
				end else begin
					old_size = seg_size[idx];
					if (first_fit(need, na)) begin
						idx = find_seg(a);
						if (idx >= 0)
							free_and_merge(idx);
						r.adr = na;
						r.ok = 1'b1;
						r.mv = 1'b1;
						r.cp = old_size[23:0];
					end
				end
			end
		end
		return r;
	endfunction

	// driver
	always @(negedge clk) begin
		heap_req_t q;
		if (!in_valid || in_taken) begin
			in_taken = 1'b0;
			if (pending_reqs.size() == 0 || $urandom_range(99) < tx_idle_pct) begin
				in_valid <= 1'b0;
			end else begin
				q = pending_reqs.pop_front();
				if (q.pick >= 0)
					q.adr = (seg_cnt == 0) ? q.adr : seg_addr(q.pick % seg_cnt) + q.adr;
				mode <= q.md;
				block_address <= q.adr;
				request_size <= q.sz;
				in_valid <= 1'b1;
			end
		end
	end

	// receiver with optional long hold-off
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// input transfer: predict
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			replies_due.push_back(predict_heap_reply(mode, block_address,
				32'(request_size)));
			in_taken = 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin
		heap_reply_t e;
		if (arst_n && out_valid && out_ready) begin
			if (replies_due.size() == 0) begin
				$error("unexpected result transfer");
				errors++;
			end else begin
				e = replies_due.pop_front();
				if (result_address !== e.adr) begin
					$error("result_address exp %h got %h", e.adr, result_address);
					errors++;
				end
				if (success !== e.ok) begin
					$error("success exp %b got %b", e.ok, success);
					errors++;
				end
				if (moved !== e.mv) begin
					$error("moved exp %b got %b", e.mv, moved);
					errors++;
				end
				if (copy_bytes !== e.cp) begin
					$error("copy_bytes exp %h got %h", e.cp, copy_bytes);
					errors++;
				end
			end
		end
	end

	task automatic push_req(logic [1:0] md, int pick, logic [31:0] adr, logic [23:0] sz);
		heap_req_t q;
		q.md = md;
		q.pick = pick;
		q.adr = adr;
		q.sz = sz;
		pending_reqs.push_back(q);
	endtask

	task automatic drain();
		while (pending_reqs.size() != 0 || in_valid || replies_due.size() != 0)
			@(posedge clk);
		repeat (500) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == 2'(CFG_BASE))
			base_reg = val;
		else
			bytes_reg = val & 32'h1FF_FFFF;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_reqs(int n, int big_pct);
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 45)
				push_req(MODE_ALLOC, -1, 0, ($urandom_range(99) < big_pct) ?
					24'($urandom_range(4096, 1)) : 24'($urandom_range(200, 1)));
			else if (r < 70)
				push_req(MODE_REL, $urandom, 0, 0);
			else if (r < 88)
				push_req(MODE_RSZ, $urandom, 0, 24'($urandom_range(400)));
			else if (r < 93)
				push_req(2'($urandom_range(3)), $urandom, 32'($urandom_range(15)),
					24'($urandom_range(300)));
			else
				push_req(2'($urandom_range(3)), -1, $urandom, 24'($urandom));
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		// directed
		push_req(MODE_ALLOC, -1, 0, 0);
		push_req(MODE_ALLOC, -1, 0, 24'hFF_FFFF);
		push_req(MODE_ALLOC, -1, 0, 1);
		push_req(MODE_ALLOC, -1, 0, 8);
		push_req(MODE_ALLOC, -1, 0, 9);
		push_req(MODE_ALLOC, -1, 0, 100);
		push_req(MODE_REL, -1, 0, 0);
		push_req(MODE_REL, -1, 32'd123, 0);
		push_req(MODE_REL, 3, 0, 0);
		push_req(MODE_REL, 3, 0, 0);
		push_req(MODE_ALLOC, -1, 0, 16);
		push_req(MODE_RSZ, -1, 0, 16);
		push_req(MODE_RSZ, 0, 0, 0);
		push_req(MODE_RSZ, -1, 32'hFFFF_FFFF, 8);
		push_req(MODE_RSZ, 1, 0, 4);
		push_req(MODE_RSZ, 1, 0, 40);
		push_req(MODE_REL, 2, 0, 0);
		push_req(MODE_RSZ, 1, 0, 60);
		push_req(MODE_RSZ, 0, 0, 24'hFF_FFFF);
		push_req(2'd3, 0, 0, 8);
		push_req(MODE_ALLOC, -1, 0, 24'hAA_AAAA);
		push_req(MODE_ALLOC, -1, 0, 24'h55_5555);
		drain();
		write_reg(2'(CFG_BASE), 32'h0);
		write_reg(2'(CFG_BYTES), 32'h100_0000);
		tx_idle_pct = 20;
		rx_idle_pct = 85;
		random_reqs(350, 30);
		drain();
		write_reg(2'(CFG_BASE), 32'hFFFF_FFF8);
		write_reg(2'(CFG_BYTES), 32'd64);
		random_reqs(100, 0);
		drain();
		write_reg(2'(CFG_BASE), $urandom);
		write_reg(2'(CFG_BYTES), 32'($urandom_range(8192, 2048)));
		tx_idle_pct = 85;
		rx_idle_pct = 20;
		random_reqs(320, 10);
		drain();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_left = 3000;
		random_reqs(320, 20);
		drain();
		if (errors == 0 && replies_due.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end
endmodule
